### rtl/ptc_pkg.sv
// ptc_pkg: widths, constants and register indexes for pressure/temperature compensation
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

   // field widths
   localparam int RAW_W      = 24;
   localparam int CAL_W      = 16;
   localparam int PRES_W     = 32;
   localparam int TENTHS_W   = 16;
   localparam int CSR_ADDR_W = 3;

   // internal datapath widths
   localparam int DT_W   = 26;  // dT, signed
   localparam int MUL_W  = 43;  // dT times a calibration word
   localparam int DSQ_W  = 48;  // dT squared, unsigned
   localparam int TEMP_W = 21;  // temperature in hundredths, signed
   localparam int T2_W   = 17;  // dT squared over 2^31
   localparam int DD_W   = 34;  // (TEMP - 2000) squared in the cold branch
   localparam int CORR_W = 40;  // OFF and SENS, signed
   localparam int LO_W   = 18;  // low slice of SENS for the split multiply
   localparam int PROD_W = 64;  // D1 times SENS
   localparam int QUO_W  = 43;  // D1 * SENS / 2^21
   localparam int DIFF_W = 44;  // minus OFF
   localparam int PQ_W   = 31;  // that over 2^13
   localparam int MAG_W  = 20;  // temperature magnitude for the divide by ten
   localparam int Q10_W  = 17;

   // shift amounts of the power-of-two divides and scalings
   localparam int T_SHIFT   = 23;
   localparam int O_SHIFT   = 7;
   localparam int S_SHIFT   = 8;
   localparam int DSQ_SHIFT = 31;
   localparam int P_SHIFT   = 21;
   localparam int X_SHIFT   = 13;
   localparam int D10_SHIFT = 24;
   localparam int OFF_SCALE_SHIFT  = 16;
   localparam int SENS_SCALE_SHIFT = 15;

   localparam int NUM_STAGES = 11;

   localparam logic signed [TEMP_W-1:0] TEMP_BASE = TEMP_W'(2000);
   // ceil(2^24 / 10), exact for magnitudes below 2^22
   localparam logic [20:0] DIV10_MUL = 21'd1677722;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SENS  = 3'd0,
      CSR_OFF   = 3'd1,
      CSR_TCS   = 3'd2,
      CSR_TCO   = 3'd3,
      CSR_TREF  = 3'd4,
      CSR_TSENS = 3'd5
   } csr_index_type;

endpackage
`default_nettype wire

### rtl/ptc_req_if.sv
// ptc_req_if: request channel carrying a pair of raw conversions
`timescale 1ns / 1ps
`default_nettype none
interface ptc_req_if import ptc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] pressure_raw;
   logic [RAW_W-1:0] temp_raw;

   modport source (output valid, output pressure_raw, output temp_raw, input ready);
   modport sink   (input valid, input pressure_raw, input temp_raw, output ready);
endinterface
`default_nettype wire

### rtl/ptc_rsp_if.sv
// ptc_rsp_if: result channel carrying compensated pressure and temperature
`timescale 1ns / 1ps
`default_nettype none
interface ptc_rsp_if import ptc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [PRES_W-1:0]          pressure_scaled;
   logic signed [TENTHS_W-1:0] temp_tenths;

   modport source (output valid, output pressure_scaled, output temp_tenths, input ready);
   modport sink   (input valid, input pressure_scaled, input temp_tenths, output ready);
endinterface
`default_nettype wire

### rtl/pressure_temperature_compensation.sv
// pressure_temperature_compensation: pipelined second-order sensor compensation
//
//   channel  direction  payload                               handshake
//   req_ch   in         pressure_raw[24], temp_raw[24]        valid/ready
//   rsp_ch   out        pressure_scaled[32], temp_tenths[16s] valid/ready
//   csr      in         csr_addr[3], csr_wdata[16]            csr_we, no wait
//
// eleven register stages; a request enters every cycle unless a stall on rsp_ch backs up
// to the first stage. the latency is set by the split 24x40 multiply and the
// chain of wide adds behind it. each stage holds its item until the next one
// frees up, so bubbles close up and a stall on rsp_ch loses nothing.
// synchronous reset clears the valid bits and the calibration words.
`timescale 1ns / 1ps
`default_nettype none
module pressure_temperature_compensation import ptc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CAL_W-1:0]      csr_wdata,
   ptc_req_if.sink                    req_ch,
   ptc_rsp_if.source                  rsp_ch
);

   // calibration words
   logic [CAL_W-1:0] cal_sens_ff, cal_off_ff, cal_tcs_ff, cal_tco_ff, cal_tref_ff, cal_tsens_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_sens_ff  <= '0;
         cal_off_ff   <= '0;
         cal_tcs_ff   <= '0;
         cal_tco_ff   <= '0;
         cal_tref_ff  <= '0;
         cal_tsens_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SENS:  cal_sens_ff  <= csr_wdata;
            CSR_OFF:   cal_off_ff   <= csr_wdata;
            CSR_TCS:   cal_tcs_ff   <= csr_wdata;
            CSR_TCO:   cal_tco_ff   <= csr_wdata;
            CSR_TREF:  cal_tref_ff  <= csr_wdata;
            CSR_TSENS: cal_tsens_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // pipeline control
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES:0]   adv;

   always_comb begin
      adv[NUM_STAGES] = rsp_ch.ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_ch.valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_ch.ready = adv[0];
   assign rsp_ch.valid = v_ff[NUM_STAGES-1];

   // stage 1: dT
   logic [RAW_W-1:0]       s1_d1_ff;
   logic signed [DT_W-1:0] s1_dt_ff, s1_dt_in;
   assign s1_dt_in = $signed({2'b00, req_ch.temp_raw}) - $signed({2'b00, cal_tref_ff, 8'h00});

   // stage 2: products with dT
   logic [RAW_W-1:0]            s2_d1_ff;
   logic signed [MUL_W-1:0]     s2_mt_ff, s2_mt_in, s2_mo_ff, s2_mo_in, s2_ms_ff, s2_ms_in;
   logic signed [2*DT_W-1:0]    dt_sq;
   logic [DSQ_W-1:0]            s2_dsq_ff;
   assign s2_mt_in = s1_dt_ff * $signed({1'b0, cal_tsens_ff});
   assign s2_mo_in = s1_dt_ff * $signed({1'b0, cal_tco_ff});
   assign s2_ms_in = s1_dt_ff * $signed({1'b0, cal_tcs_ff});
   assign dt_sq    = s1_dt_ff * s1_dt_ff;

   // stage 3: first-order TEMP, OFF, SENS
   logic signed [MUL_W-1:0]  mt_b, mo_b, ms_b;
   logic [RAW_W-1:0]         s3_d1_ff;
   logic signed [TEMP_W-1:0] s3_temp_ff, s3_temp_in;
   logic signed [CORR_W-1:0] s3_off_ff, s3_off_in, s3_sens_ff, s3_sens_in;
   logic [T2_W-1:0]          s3_t2_ff;

   // round toward zero: add divisor minus one to negatives before the shift
   assign mt_b = s2_mt_ff + (s2_mt_ff[MUL_W-1] ? MUL_W'((1 << T_SHIFT) - 1) : '0);
   assign mo_b = s2_mo_ff + (s2_mo_ff[MUL_W-1] ? MUL_W'((1 << O_SHIFT) - 1) : '0);
   assign ms_b = s2_ms_ff + (s2_ms_ff[MUL_W-1] ? MUL_W'((1 << S_SHIFT) - 1) : '0);
   assign s3_temp_in = TEMP_BASE + TEMP_W'($signed(mt_b[MUL_W-1:T_SHIFT]));
   assign s3_off_in  = CORR_W'($signed({1'b0, cal_off_ff, OFF_SCALE_SHIFT'(0)}))
                     + CORR_W'($signed(mo_b[MUL_W-1:O_SHIFT]));
   assign s3_sens_in = CORR_W'($signed({1'b0, cal_sens_ff, SENS_SCALE_SHIFT'(0)}))
                     + CORR_W'($signed(ms_b[MUL_W-1:S_SHIFT]));

   // stage 4: cold test and (TEMP - 2000) squared
   logic signed [TEMP_W-1:0]   d_cold;
   logic signed [2*TEMP_W-1:0] d_sq;
   logic [RAW_W-1:0]           s4_d1_ff;
   logic signed [TEMP_W-1:0]   s4_temp_ff;
   logic signed [CORR_W-1:0]   s4_off_ff, s4_sens_ff;
   logic [T2_W-1:0]            s4_t2_ff;
   logic [DD_W-1:0]            s4_dd_ff;
   logic                       s4_cold_ff;
   assign d_cold = s3_temp_ff - TEMP_BASE;
   assign d_sq   = d_cold * d_cold;

   // stage 5: second-order correction below 20.00 C
   logic [DD_W+2:0]          dd6;
   logic [DD_W+1:0]          dd3;
   logic [RAW_W-1:0]         s5_d1_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff, s5_temp_in;
   logic signed [CORR_W-1:0] s5_off_ff, s5_off_in, s5_sens_ff, s5_sens_in;
   assign dd6 = {1'b0, s4_dd_ff, 2'b00} + {2'b00, s4_dd_ff, 1'b0};
   assign dd3 = {1'b0, s4_dd_ff, 1'b0} + {2'b00, s4_dd_ff};
   always_comb begin
      s5_temp_in = s4_temp_ff;
      s5_off_in  = s4_off_ff;
      s5_sens_in = s4_sens_ff;
      if (s4_cold_ff) begin
         s5_temp_in = s4_temp_ff - $signed(TEMP_W'(s4_t2_ff));
         s5_off_in  = s4_off_ff - $signed(CORR_W'(dd6[DD_W+2:2]));
         s5_sens_in = s4_sens_ff - $signed(CORR_W'(dd3[DD_W+1:3]));
      end
   end

   // stage 6: split D1 * SENS, temperature magnitude over ten
   logic [TEMP_W-1:0]                temp_mag;
   logic [MAG_W+20:0]                q10_full;
   logic [RAW_W+LO_W-1:0]            s6_plo_ff;
   logic signed [RAW_W+CORR_W-LO_W:0] s6_phi_ff, s6_phi_in;
   logic signed [CORR_W-1:0]         s6_off_ff;
   logic [Q10_W-1:0]                 s6_q10_ff;
   logic                             s6_neg_ff;
   assign s6_phi_in = $signed({1'b0, s5_d1_ff}) * $signed(s5_sens_ff[CORR_W-1:LO_W]);
   assign temp_mag  = s5_temp_ff[TEMP_W-1] ? TEMP_W'(-s5_temp_ff) : TEMP_W'(s5_temp_ff);
   assign q10_full  = temp_mag[MAG_W-1:0] * DIV10_MUL;

   // stage 7: recombine the product, sign of the tenths
   logic signed [PROD_W-1:0] s7_prod_ff, s7_prod_in;
   logic signed [CORR_W-1:0] s7_off_ff;
   logic [Q10_W-1:0]         tenths_full;
   logic [TENTHS_W-1:0]      s7_tenths_ff;
   assign s7_prod_in  = (PROD_W'(s6_phi_ff) <<< LO_W) + $signed(PROD_W'(s6_plo_ff));
   assign tenths_full = s6_neg_ff ? Q10_W'(-s6_q10_ff) : s6_q10_ff;

   // stage 8: divide by 2^21
   logic signed [PROD_W-1:0] prod_b;
   logic signed [QUO_W-1:0]  s8_quo_ff;
   logic signed [CORR_W-1:0] s8_off_ff;
   logic [TENTHS_W-1:0]      s8_tenths_ff;
   assign prod_b = s7_prod_ff + (s7_prod_ff[PROD_W-1] ? PROD_W'((1 << P_SHIFT) - 1) : '0);

   // stage 9: minus OFF
   logic signed [DIFF_W-1:0] s9_diff_ff;
   logic [TENTHS_W-1:0]      s9_tenths_ff;

   // stage 10: divide by 2^13
   logic signed [DIFF_W-1:0] diff_b;
   logic [PRES_W-1:0]        s10_pres_ff;
   logic [TENTHS_W-1:0]      s10_tenths_ff;
   assign diff_b = s9_diff_ff + (s9_diff_ff[DIFF_W-1] ? DIFF_W'((1 << X_SHIFT) - 1) : '0);

   // stage 11: times 100 into the output register
   logic [PRES_W-1:0]   s11_pres_ff, s11_pres_in;
   logic [TENTHS_W-1:0] s11_tenths_ff;
   assign s11_pres_in = (s10_pres_ff << 6) + (s10_pres_ff << 5) + (s10_pres_ff << 2);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_d1_ff <= req_ch.pressure_raw;
         s1_dt_ff <= s1_dt_in;
      end
      if (adv[1]) begin
         s2_d1_ff  <= s1_d1_ff;
         s2_mt_ff  <= s2_mt_in;
         s2_mo_ff  <= s2_mo_in;
         s2_ms_ff  <= s2_ms_in;
         s2_dsq_ff <= dt_sq[DSQ_W-1:0];
      end
      if (adv[2]) begin
         s3_d1_ff   <= s2_d1_ff;
         s3_temp_ff <= s3_temp_in;
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
         s3_t2_ff   <= s2_dsq_ff[DSQ_W-1:DSQ_SHIFT];
      end
      if (adv[3]) begin
         s4_d1_ff   <= s3_d1_ff;
         s4_temp_ff <= s3_temp_ff;
         s4_off_ff  <= s3_off_ff;
         s4_sens_ff <= s3_sens_ff;
         s4_t2_ff   <= s3_t2_ff;
         s4_dd_ff   <= d_sq[DD_W-1:0];
         s4_cold_ff <= s3_temp_ff < TEMP_BASE;
      end
      if (adv[4]) begin
         s5_d1_ff   <= s4_d1_ff;
         s5_temp_ff <= s5_temp_in;
         s5_off_ff  <= s5_off_in;
         s5_sens_ff <= s5_sens_in;
      end
      if (adv[5]) begin
         s6_plo_ff <= s5_d1_ff * s5_sens_ff[LO_W-1:0];
         s6_phi_ff <= s6_phi_in;
         s6_off_ff <= s5_off_ff;
         s6_q10_ff <= q10_full[MAG_W+20:D10_SHIFT];
         s6_neg_ff <= s5_temp_ff[TEMP_W-1];
      end
      if (adv[6]) begin
         s7_prod_ff   <= s7_prod_in;
         s7_off_ff    <= s6_off_ff;
         s7_tenths_ff <= tenths_full[TENTHS_W-1:0];
      end
      if (adv[7]) begin
         s8_quo_ff    <= $signed(prod_b[PROD_W-1:P_SHIFT]);
         s8_off_ff    <= s7_off_ff;
         s8_tenths_ff <= s7_tenths_ff;
      end
      if (adv[8]) begin
         s9_diff_ff   <= DIFF_W'(s8_quo_ff) - DIFF_W'(s8_off_ff);
         s9_tenths_ff <= s8_tenths_ff;
      end
      if (adv[9]) begin
         s10_pres_ff   <= PRES_W'($signed(diff_b[DIFF_W-1:X_SHIFT]));
         s10_tenths_ff <= s9_tenths_ff;
      end
      if (adv[10]) begin
         s11_pres_ff   <= s11_pres_in;
         s11_tenths_ff <= s10_tenths_ff;
      end
   end

   assign rsp_ch.pressure_scaled = s11_pres_ff;
   assign rsp_ch.temp_tenths     = $signed(s11_tenths_ff);

   // an accepted request always lands in the first stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v_ff[0])
      else $error("accepted request missing from first stage");

   // a stalled output keeps the item queued behind it
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v_ff[NUM_STAGES-1] && !rsp_ch.ready && v_ff[NUM_STAGES-2] |=> v_ff[NUM_STAGES-2])
      else $error("item behind a stalled output was dropped");

   // after a result is taken, a new one only comes from the stage before
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      v_ff[NUM_STAGES-1] && rsp_ch.ready |=> !v_ff[NUM_STAGES-1] || $past(v_ff[NUM_STAGES-2]))
      else $error("result appeared without a source item");

endmodule
`default_nettype wire
